[design/owbm_pkg.sv]
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, register indexes, reset values and widths for the single-wire
// bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   // Defaults of the top-level parameters.
   localparam int BITS_PER_TRANSFER_DEF = 8;
   localparam int COUNT_WIDTH_DEF       = 10;

   // Port widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_LOW_TIME = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_RECOVERY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WRITE_ONE_LOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_TIME      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_LOW_TIME  = 3'd5;

   // Register reset values.
   localparam logic [9:0] RESET_LOW_TIME_RST = 10'd480;
   localparam logic [9:0] PRESENCE_WAIT_RST  = 10'd80;
   localparam logic [9:0] RESET_RECOVERY_RST = 10'd400;
   localparam logic [5:0] WRITE_ONE_LOW_RST  = 6'd1;
   localparam logic [7:0] SLOT_TIME_RST      = 8'd60;
   localparam logic [5:0] READ_LOW_TIME_RST  = 6'd2;

   // Operation codes; the request mode field uses the same encoding.
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_RST_LOW     = 3'd1,
      PH_RST_WAIT    = 3'd2,
      PH_RST_TAIL    = 3'd3,
      PH_BIT_LOW     = 3'd4,
      PH_READ_SAMPLE = 3'd5,
      PH_BIT_REST    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [9:0] presence_wait;
      logic [9:0] reset_recovery;
      logic [5:0] write_one_low;
      logic [7:0] slot_time;
      logic [5:0] read_low_time;
   } cfg_type;

   typedef struct packed {
      logic       rejected;
      logic [7:0] read_data;
      logic       presence;
      logic       done_res;
      logic       busy_res;
      logic       drive_low;
   } rsp_type;

endpackage

[design/owbm_csr.sv]
// ----------------------------------------------------------------------------
// owbm_csr
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [owbm_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]  wr_data,
   output owbm_pkg::cfg_type               cfg
);
   import owbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_RESET_LOW_TIME: cfg_in.reset_low_time = wr_data;
            REG_PRESENCE_WAIT:  cfg_in.presence_wait  = wr_data;
            REG_RESET_RECOVERY: cfg_in.reset_recovery = wr_data;
            REG_WRITE_ONE_LOW:  cfg_in.write_one_low  = wr_data[5:0];
            REG_SLOT_TIME:      cfg_in.slot_time      = wr_data[7:0];
            REG_READ_LOW_TIME:  cfg_in.read_low_time  = wr_data[5:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time <= RESET_LOW_TIME_RST;
         cfg_ff.presence_wait  <= PRESENCE_WAIT_RST;
         cfg_ff.reset_recovery <= RESET_RECOVERY_RST;
         cfg_ff.write_one_low  <= WRITE_ONE_LOW_RST;
         cfg_ff.slot_time      <= SLOT_TIME_RST;
         cfg_ff.read_low_time  <= READ_LOW_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/owbm_step.sv]
// ----------------------------------------------------------------------------
// owbm_step
// Bus sequencer state and the per-tick step logic. The state advances by one
// tick whenever step_en is high; the result of that tick is given at rsp.
// ----------------------------------------------------------------------------
module owbm_step #(
   parameter int BITS_PER_TRANSFER = owbm_pkg::BITS_PER_TRANSFER_DEF,
   parameter int COUNT_WIDTH       = owbm_pkg::COUNT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [1:0]        mode,
   input  logic [7:0]        write_data,
   input  logic              line_level,
   input  owbm_pkg::cfg_type cfg,
   output owbm_pkg::rsp_type rsp
);
   import owbm_pkg::*;

   localparam int CNT_W = $clog2(BITS_PER_TRANSFER + 1);
   localparam int IDX_W = (BITS_PER_TRANSFER > 1) ? $clog2(BITS_PER_TRANSFER) : 1;
   localparam int BYTE_W = (BITS_PER_TRANSFER < 8) ? BITS_PER_TRANSFER : 8;
   localparam logic [15:0] TIME_CAP = 16'((1 << COUNT_WIDTH) - 1);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(BITS_PER_TRANSFER);

   phase_type                      phase_ff, phase_in;
   op_type                         op_ff, op_in;
   logic [COUNT_WIDTH-1:0]         time_ff, time_in;
   logic [CNT_W-1:0]               bits_ff, bits_in;
   logic [BITS_PER_TRANSFER-1:0]   shift_ff, shift_in;
   logic                           pres_ff, pres_in;
   logic [7:0]                     last_read_ff, last_read_in;
   logic                           done_flag;
   logic                           drive_flag;
   logic                           reject_flag;

   // Zero counts as one tick; values above the counter saturate.
   function automatic logic [COUNT_WIDTH-1:0] duration(input logic [9:0] v);
      logic [9:0] v1;
      v1 = (v == 10'd0) ? 10'd1 : v;
      if ({6'd0, v1} > TIME_CAP) begin
         return TIME_CAP[COUNT_WIDTH-1:0];
      end
      return COUNT_WIDTH'(v1);
   endfunction

   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      time_in      = time_ff;
      bits_in      = bits_ff;
      shift_in     = shift_ff;
      pres_in      = pres_ff;
      last_read_in = last_read_ff;
      done_flag    = 1'b0;
      drive_flag   = 1'b0;
      reject_flag  = 1'b0;

      // Command decode: a starting command is already the first tick.
      if (phase_ff == PH_IDLE) begin
         if (mode != OP_NONE) begin
            op_in   = op_type'(mode);
            bits_in = '0;
            if (op_type'(mode) == OP_RESET) begin
               phase_in = PH_RST_LOW;
               time_in  = duration(cfg.reset_low_time);
            end else begin
               shift_in = '0;
               if (op_type'(mode) == OP_WRITE) begin
                  shift_in[BYTE_W-1:0] = write_data[BYTE_W-1:0];
               end
               phase_in = PH_BIT_LOW;
               if (op_type'(mode) == OP_READ) begin
                  time_in = duration({4'd0, cfg.read_low_time});
               end else if (shift_in[0]) begin
                  time_in = duration({4'd0, cfg.write_one_low});
               end else begin
                  time_in = duration({2'd0, cfg.slot_time});
               end
            end
         end
      end else if (mode != OP_NONE) begin
         reject_flag = 1'b1;
      end

      // One tick of the running operation.
      if (phase_in != PH_IDLE) begin
         drive_flag = (phase_in == PH_RST_LOW) || (phase_in == PH_BIT_LOW);
         if (time_in != '0) begin
            time_in = time_in - 1'b1;
         end
         if (time_in == '0) begin
            case (phase_in)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
                  time_in  = duration(cfg.presence_wait);
               end
               PH_RST_WAIT: begin
                  pres_in  = ~line_level;
                  phase_in = PH_RST_TAIL;
                  time_in  = duration(cfg.reset_recovery);
               end
               PH_BIT_LOW: begin
                  if (op_in == OP_READ) begin
                     phase_in = PH_READ_SAMPLE;
                     time_in  = duration(10'd1);
                  end else if (shift_in[bits_in[IDX_W-1:0]]) begin
                     phase_in = PH_BIT_REST;
                     time_in  = duration({2'd0, cfg.slot_time});
                  end else begin
                     phase_in = PH_BIT_REST;
                     time_in  = duration(10'd1);
                  end
               end
               PH_READ_SAMPLE: begin
                  if (line_level) begin
                     shift_in[bits_in[IDX_W-1:0]] = 1'b1;
                  end
                  phase_in = PH_BIT_REST;
                  time_in  = duration({2'd0, cfg.slot_time});
               end
               PH_BIT_REST: begin
                  bits_in = bits_in + 1'b1;
                  if (bits_in == LAST_COUNT) begin
                     if (op_in == OP_READ) begin
                        last_read_in = 8'(shift_in[BYTE_W-1:0]);
                     end
                     phase_in  = PH_IDLE;
                     time_in   = '0;
                     op_in     = OP_NONE;
                     done_flag = 1'b1;
                  end else begin
                     phase_in = PH_BIT_LOW;
                     if (op_in == OP_READ) begin
                        time_in = duration({4'd0, cfg.read_low_time});
                     end else if (shift_in[bits_in[IDX_W-1:0]]) begin
                        time_in = duration({4'd0, cfg.write_one_low});
                     end else begin
                        time_in = duration({2'd0, cfg.slot_time});
                     end
                  end
               end
               default: begin
                  // Tail of a reset, or a phase code that means nothing.
                  phase_in  = PH_IDLE;
                  time_in   = '0;
                  op_in     = OP_NONE;
                  done_flag = 1'b1;
               end
            endcase
         end
      end

      rsp.drive_low = drive_flag;
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done_flag;
      rsp.presence  = pres_in;
      rsp.read_data = last_read_in;
      rsp.rejected  = reject_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         op_ff        <= OP_NONE;
         time_ff      <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         pres_ff      <= 1'b0;
         last_read_ff <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         time_ff      <= time_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         pres_ff      <= pres_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule

[design/one_wire_bus_master_unit.sv]
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Single-wire bus master timed by one tick item per microsecond.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   req_     in         tuser: mode; tdata: write_data, line_level
//   rsp_     out        tdata: drive_low, busy_res, presence, read_data,
//                       rejected; tlast: done_res
//   csr_     in         csr_index selects a timing register, csr_data value
//
// Each tick item is taken into an input register and stepped through the
// sequencer when the output register is free or being drained; the result
// lands in the output register. While rsp_tready stays high, one item per
// cycle is sustained. A stall on the result side holds the output register
// and the input register, so no tick is ever lost. Reset is synchronous and
// leaves the sequencer idle with the timing registers at their default values.
//
// The sequencer walks reset, write and read operations as a phase machine with
// a down counter per phase; each tick decrements the counter and, when it runs
// out, the next phase is loaded from the timing registers. A command that
// arrives while an operation runs is ignored and flagged as rejected, but its
// item still counts as one tick.
//
module one_wire_bus_master_unit #(
   parameter int BITS_PER_TRANSFER = owbm_pkg::BITS_PER_TRANSFER_DEF,
   parameter int COUNT_WIDTH       = owbm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Tick and command items.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [owbm_pkg::REQ_TDATA_W-1:0] req_tdata,   // [7:0] write_data, [8] line_level
   input  logic [owbm_pkg::REQ_TUSER_W-1:0] req_tuser,   // [1:0] mode
   // Per-tick results.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [owbm_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [0] drive_low, [1] busy_res,
                                                          // [2] presence, [10:3] read_data,
                                                          // [11] rejected
   output logic                             rsp_tlast,   // done_res
   // Timing register writes.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [owbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import owbm_pkg::*;

   cfg_type    cfg;
   rsp_type    step_rsp;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_mode_ff;
   logic [7:0] in_wdata_ff;
   logic       in_line_ff;
   logic       in_take;
   logic       step_move;

   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;

   // Register writes are always taken at once.
   assign csr_ready = 1'b1;

   owbm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // The held item steps when the output register is free or being drained.
   assign step_move  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_move;
   assign in_take    = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (step_move) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_mode_ff  <= req_tuser[1:0];
         in_wdata_ff <= req_tdata[7:0];
         in_line_ff  <= req_tdata[8];
      end
      if (step_move) begin
         out_ff <= step_rsp;
      end
   end

   owbm_step #(
      .BITS_PER_TRANSFER (BITS_PER_TRANSFER),
      .COUNT_WIDTH       (COUNT_WIDTH)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_move),
      .mode       (in_mode_ff),
      .write_data (in_wdata_ff),
      .line_level (in_line_ff),
      .cfg        (cfg),
      .rsp        (step_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.done_res;
   assign rsp_tdata  = {4'd0, out_ff.rejected, out_ff.read_data, out_ff.presence,
                        out_ff.busy_res, out_ff.drive_low};

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the single-wire bus master: tick items go in on the
// request stream, and every per-tick result is checked field by field against
// a cycle-free model of the reset, write and read sequencer kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import owbm_pkg::*;

   localparam int NBITS = BITS_PER_TRANSFER_DEF;

   // Indexes past the last timing register. Writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

   // How the sampled line level is chosen for the ticks of one operation.
   localparam int LINE_LOW    = 0;
   localparam int LINE_HIGH   = 1;
   localparam int LINE_RANDOM = 2;

   // Idle cycles after the stimulus drains, before a register write or the end.
   localparam int SETTLE_CYCLES = 6;

   typedef struct {
      op_type     mode;
      logic [7:0] wdata;
      logic       line;
   } tick_item_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   one_wire_bus_master_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sequencer model. It mirrors the phase machine one tick at a time: the
   // tick that starts an operation is already its first tick, each phase of
   // length n covers n ticks, and a zero register value counts as one tick.
   // ------------------------------------------------------------------------
   cfg_type     timing;
   phase_type   seq_phase;
   logic [9:0]  seq_left;
   int unsigned seq_bit;
   logic [7:0]  seq_shift;
   logic        seq_presence;
   op_type      seq_op;
   logic [7:0]  seq_last_read;
   logic        seq_done;

   // Run statistics for the closing summary.
   int unsigned n_started[4];
   int unsigned n_rejected;
   int unsigned n_samples;
   int unsigned n_replies;
   int unsigned n_checked;
   int unsigned n_errors;

   tick_item_type ticks_to_send[$];
   rsp_type       due_results[$];
   int unsigned   n_queued;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   function automatic logic [9:0] span(logic [9:0] v);
      return (v == '0) ? 10'd1 : v;
   endfunction

   function automatic void enter(phase_type p, logic [9:0] v);
      seq_phase = p;
      seq_left  = span(v);
   endfunction

   function automatic logic bit_now();
      return (seq_bit < NBITS) ? seq_shift[seq_bit] : 1'b0;
   endfunction

   function automatic void start_bit();
      if (seq_op == OP_READ)
         enter(PH_BIT_LOW, 10'(timing.read_low_time));
      else if (bit_now())
         enter(PH_BIT_LOW, 10'(timing.write_one_low));
      else
         enter(PH_BIT_LOW, 10'(timing.slot_time));
   endfunction

   function automatic void finish_op();
      seq_phase = PH_IDLE;
      seq_left  = '0;
      seq_op    = OP_NONE;
      seq_done  = 1'b1;
   endfunction

   // Called when the counter of the current phase runs out on this tick.
   function automatic void phase_end(logic line);
      case (seq_phase)
         PH_RST_LOW: begin
            enter(PH_RST_WAIT, timing.presence_wait);
         end
         PH_RST_WAIT: begin
            // A device answers by holding the line low.
            seq_presence = !line;
            n_samples++;
            if (!line)
               n_replies++;
            enter(PH_RST_TAIL, timing.reset_recovery);
         end
         PH_RST_TAIL: begin
            finish_op();
         end
         PH_BIT_LOW: begin
            if (seq_op == OP_READ)
               enter(PH_READ_SAMPLE, 10'd1);
            else if (bit_now())
               enter(PH_BIT_REST, 10'(timing.slot_time));
            else
               enter(PH_BIT_REST, 10'd1);
         end
         PH_READ_SAMPLE: begin
            if (line && seq_bit < NBITS)
               seq_shift[seq_bit] = 1'b1;
            enter(PH_BIT_REST, 10'(timing.slot_time));
         end
         PH_BIT_REST: begin
            seq_bit++;
            if (seq_bit >= NBITS) begin
               if (seq_op == OP_READ)
                  seq_last_read = seq_shift;
               finish_op();
            end else begin
               start_bit();
            end
         end
         default: begin
            finish_op();
         end
      endcase
   endfunction

   function automatic rsp_type next_tick_result(op_type mode, logic [7:0] wdata,
                                                logic line);
      rsp_type r;
      r = '0;
      seq_done = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (mode != OP_NONE) begin
            seq_op  = mode;
            seq_bit = 0;
            n_started[mode]++;
            if (mode == OP_RESET) begin
               enter(PH_RST_LOW, timing.reset_low_time);
            end else begin
               seq_shift = (mode == OP_WRITE) ? wdata : 8'h00;
               start_bit();
            end
         end
      end else if (mode != OP_NONE) begin
         // Busy: the command is dropped but the item is still a tick.
         r.rejected = 1'b1;
         n_rejected++;
      end
      if (seq_phase != PH_IDLE) begin
         r.drive_low = (seq_phase == PH_RST_LOW || seq_phase == PH_BIT_LOW);
         if (seq_left != '0)
            seq_left--;
         if (seq_left == '0)
            phase_end(line);
      end
      r.busy_res  = (seq_phase != PH_IDLE);
      r.done_res  = seq_done;
      r.presence  = seq_presence;
      r.read_data = seq_last_read;
      return r;
   endfunction

   // Number of ticks an operation takes under the current timing, counting
   // the tick that starts it and the tick that finishes it.
   function automatic int unsigned op_length(op_type op, logic [7:0] data);
      int unsigned n;
      n = 0;
      case (op)
         OP_RESET: begin
            n = span(timing.reset_low_time) + span(timing.presence_wait) +
                span(timing.reset_recovery);
         end
         OP_WRITE: begin
            for (int b = 0; b < NBITS; b++)
               n += data[b] ? span(10'(timing.write_one_low)) + span(10'(timing.slot_time))
                            : span(10'(timing.slot_time)) + 1;
         end
         OP_READ: begin
            n = NBITS * (span(10'(timing.read_low_time)) + 1 + span(10'(timing.slot_time)));
         end
         default: begin
            n = 1;
         end
      endcase
      return n;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      n_errors++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. A transfer happens at an edge where tvalid and tready
   // were both high; the model is stepped for exactly that item. A new item
   // is offered only when the slot is free, and the sender idles at random.
   // ------------------------------------------------------------------------
   tick_item_type in_flight;

   always @(posedge clock) begin : req_driver
      tick_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            due_results.push_back(next_tick_result(in_flight.mode, in_flight.wdata,
                                                   in_flight.line));
         if (!req_tvalid || req_tready) begin
            if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt        = ticks_to_send.pop_front();
               in_flight  = nxt;
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.mode;
               req_tdata  <= {7'd0, nxt.line, nxt.wdata};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Each result transfer is compared with the oldest
   // expectation; done travels on tlast, the other fields in tdata.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("result transfer with nothing outstanding", 1, 0);
            end else begin
               due = due_results.pop_front();
               n_checked++;
               if (rsp_tdata[0] !== due.drive_low)
                  report_mismatch("drive_low", rsp_tdata[0], due.drive_low);
               if (rsp_tdata[1] !== due.busy_res)
                  report_mismatch("busy", rsp_tdata[1], due.busy_res);
               if (rsp_tlast !== due.done_res)
                  report_mismatch("done (tlast)", rsp_tlast, due.done_res);
               if (rsp_tdata[2] !== due.presence)
                  report_mismatch("presence", rsp_tdata[2], due.presence);
               if (rsp_tdata[10:3] !== due.read_data)
                  report_mismatch("read_data", rsp_tdata[10:3], due.read_data);
               if (rsp_tdata[11] !== due.rejected)
                  report_mismatch("rejected", rsp_tdata[11], due.rejected);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers. The initial block works on the falling edge so that
   // its queue updates never race the clocked driver and monitor.
   // ------------------------------------------------------------------------
   task automatic push_tick(op_type mode, logic [7:0] wdata, logic line);
      tick_item_type t;
      t.mode  = mode;
      t.wdata = wdata;
      t.line  = line;
      ticks_to_send.push_back(t);
      n_queued++;
   endtask

   // Holds off until every queued item went out and every result came back.
   task automatic wait_drained();
      while (ticks_to_send.size() != 0 || req_tvalid || due_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      // Narrow registers keep only their low bits.
      case (idx)
         REG_RESET_LOW_TIME: timing.reset_low_time = val;
         REG_PRESENCE_WAIT:  timing.presence_wait  = val;
         REG_RESET_RECOVERY: timing.reset_recovery = val;
         REG_WRITE_ONE_LOW:  timing.write_one_low  = val[5:0];
         REG_SLOT_TIME:      timing.slot_time      = val[7:0];
         REG_READ_LOW_TIME:  timing.read_low_time  = val[5:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_timing(logic [9:0] rlow, logic [9:0] pwait, logic [9:0] rrec,
                             logic [9:0] one_low, logic [9:0] slot, logic [9:0] rd_low);
      write_reg(REG_RESET_LOW_TIME, rlow);
      write_reg(REG_PRESENCE_WAIT, pwait);
      write_reg(REG_RESET_RECOVERY, rrec);
      write_reg(REG_WRITE_ONE_LOW, one_low);
      write_reg(REG_SLOT_TIME, slot);
      write_reg(REG_READ_LOW_TIME, rd_low);
   endtask

   // Queues one operation: the command tick and then exactly the ticks it
   // needs. Commands sprinkled over the busy ticks must all be rejected, and
   // cmd_at_end puts one on the finishing tick. pause_at >= 0 makes the
   // sender wait for every outstanding result before that tick.
   task automatic run_op(op_type op, logic [7:0] data, int line_mode, int unsigned noise_pct,
                         bit cmd_at_end, int unsigned gap, int pause_at);
      int unsigned len;
      op_type      mode;
      logic        line;
      len = op_length(op, data);
      for (int unsigned k = 0; k < len; k++) begin
         if (k == 0)
            mode = op;
         else if ((cmd_at_end && k == len - 1) || $urandom_range(0, 99) < noise_pct)
            mode = op_type'($urandom_range(1, 3));
         else
            mode = OP_NONE;
         case (line_mode)
            LINE_LOW:  line = 1'b0;
            LINE_HIGH: line = 1'b1;
            default:   line = 1'($urandom_range(0, 1));
         endcase
         if (pause_at >= 0 && k == pause_at)
            wait_drained();
         push_tick(mode, (k == 0) ? data : 8'($urandom), line);
      end
      repeat (gap)
         push_tick(OP_NONE, 8'($urandom), 1'($urandom));
   endtask

   // Random operations under a random short timing until the budget of tick
   // items is used up.
   task automatic random_phase(int unsigned budget, bit with_pause);
      int unsigned first;
      op_type      op;
      logic [7:0]  data;
      int          lm;
      int unsigned pick;
      bit          pause_done;
      set_timing(10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
                 10'($urandom_range(0, 6)),
                 10'($urandom_range(0, 3) | ($urandom_range(0, 15) << 6)),
                 10'($urandom_range(0, 5) | ($urandom_range(0, 3) << 8)),
                 10'($urandom_range(0, 3) | ($urandom_range(0, 15) << 6)));
      first      = n_queued;
      pause_done = !with_pause;
      while (n_queued - first < budget) begin
         op   = op_type'($urandom_range(1, 3));
         data = 8'($urandom);
         pick = $urandom_range(0, 9);
         lm   = (pick == 0) ? LINE_LOW : (pick == 1) ? LINE_HIGH : LINE_RANDOM;
         run_op(op, data, lm, $urandom_range(0, 30), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3),
                pause_done ? -1 : int'(op_length(op, data) / 2));
         pause_done = 1'b1;
      end
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      timing        = '{reset_low_time: RESET_LOW_TIME_RST, presence_wait: PRESENCE_WAIT_RST,
                        reset_recovery: RESET_RECOVERY_RST, write_one_low: WRITE_ONE_LOW_RST,
                        slot_time: SLOT_TIME_RST, read_low_time: READ_LOW_TIME_RST};
      seq_phase     = PH_IDLE;
      seq_left      = '0;
      seq_bit       = 0;
      seq_shift     = '0;
      seq_presence  = 1'b0;
      seq_op        = OP_NONE;
      seq_last_read = '0;
      seq_done      = 1'b0;
      n_started     = '{default: 0};
      n_rejected    = 0;
      n_samples     = 0;
      n_replies     = 0;
      n_checked     = 0;
      n_errors      = 0;
      n_queued      = 0;
      set_idling(37, 73);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Idle ticks right after reset: presence and the read byte start at zero.
      run_op(OP_NONE, 8'h00, LINE_RANDOM, 0, 1'b0, 2, -1);
      wait_drained();

      // Directed cases under the shortest timing, zero values among it.
      set_timing(10'd0, 10'd1, 10'd2, 10'd0, 10'd2, 10'd1);
      // Writes past the last register must leave the timing alone.
      write_reg(REG_UNUSED_6, 10'h3FF);
      write_reg(REG_UNUSED_7, 10'h000);
      run_op(OP_RESET, 8'h00, LINE_LOW, 0, 1'b0, 1, -1);     // device answers
      run_op(OP_RESET, 8'h00, LINE_HIGH, 0, 1'b1, 0, -1);    // no answer, old value dropped
      run_op(OP_WRITE, 8'h00, LINE_RANDOM, 60, 1'b0, 0, -1); // busy commands of every kind
      run_op(OP_WRITE, 8'hFF, LINE_RANDOM, 0, 1'b1, 0, -1);  // starts on the tick after done
      run_op(OP_READ, 8'h00, LINE_HIGH, 0, 1'b0, 1, -1);     // all ones read back
      run_op(OP_READ, 8'hFF, LINE_LOW, 20, 1'b0, 3, -1);     // all zeros, data ignored
      run_op(OP_READ, 8'h00, LINE_RANDOM, 0, 1'b1, 0, -1);
      run_op(OP_WRITE, 8'h5A, LINE_RANDOM, 0, 1'b0, 2, -1);
      wait_drained();

      random_phase(130, 1'b0);
      wait_drained();

      set_idling(73, 37);
      random_phase(130, 1'b1);
      wait_drained();

      set_idling(0, 0);
      random_phase(130, 1'b0);
      wait_drained();
      random_phase(130, 1'b0);
      wait_drained();

      $display("Run covered %0d resets (%0d presence samples, %0d answered), %0d writes, %0d reads.",
               n_started[OP_RESET], n_samples, n_replies, n_started[OP_WRITE],
               n_started[OP_READ]);
      $display("%0d tick results checked, %0d busy commands rejected, %0d mismatches.",
               n_checked, n_rejected, n_errors);
      if (n_errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Guard against a hung handshake; far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
